FILE: rtl/core/gdn_pkg.sv
// shared types, constants and calendar arithmetic for the day number converter
package gdn_pkg;

	// default upper calendar year
	localparam int MAX_YEAR_DEF = 9999;
	// largest day number the count field can carry
	localparam int COUNT_LIMIT = 4194303;
	// bits of the year search, one pipeline stage each
	localparam int YEAR_BITS = 16;
	// reciprocal of one hundred, exact for any 16-bit dividend
	localparam logic [16:0] RECIP100 = 17'd83887;

	typedef enum logic [1:0] {
		MODE_TO_COUNT = 2'd0,
		MODE_TO_DATE  = 2'd1,
		MODE_ADD      = 2'd2,
		MODE_NONE     = 2'd3
	} mode_t;

	// item travelling through the year search
	typedef struct packed {
		logic [YEAR_BITS-1:0] yr;
		logic [21:0]          dbe;
		logic [21:0]          cnt;
		logic                 ok;
	} srch_t;

	// quotient by one hundred through a reciprocal multiply
	function automatic logic [9:0] div100(input logic [YEAR_BITS-1:0] t);
		logic [32:0] p;
		p = 33'(t) * 33'(RECIP100);
		return p[32:23];
	endfunction

	// days in years one to t, given q = t / 100
	function automatic logic [25:0] dbe(input logic [YEAR_BITS-1:0] t, input logic [9:0] q);
		return 26'(t) * 26'd365 + 26'(t[YEAR_BITS-1:2]) - 26'(q) + 26'(q[9:2]);
	endfunction

	// days before the start of month idx+1 (idx 0 to 12)
	function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
		logic [8:0] b;
		unique case (idx)
			4'd0:    b = 9'd0;
			4'd1:    b = 9'd31;
			4'd2:    b = 9'd59;
			4'd3:    b = 9'd90;
			4'd4:    b = 9'd120;
			4'd5:    b = 9'd151;
			4'd6:    b = 9'd181;
			4'd7:    b = 9'd212;
			4'd8:    b = 9'd243;
			4'd9:    b = 9'd273;
			4'd10:   b = 9'd304;
			4'd11:   b = 9'd334;
			4'd12:   b = 9'd365;
			default: b = 9'd0;
		endcase
		return b + {8'd0, leap && (idx >= 4'd2) && (idx <= 4'd12)};
	endfunction

	// remainder by seven: octal digits fold since eight is one mod seven
	function automatic logic [2:0] mod7(input logic [21:0] v);
		logic [23:0] x;
		logic [5:0]  s;
		logic [3:0]  s2;
		logic [2:0]  s3;
		x = {2'b00, v};
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 6'(x[3*i +: 3]);
		end
		s2 = 4'(s[5:3]) + 4'(s[2:0]);
		s3 = 3'(s2[3]) + s2[2:0];
		return (s3 == 3'd7) ? 3'd0 : s3;
	endfunction

endpackage

FILE: rtl/core/gdn_front.sv
// front stages: date check, date to day number and offset addition
module gdn_front #(
	parameter int MAX_YEAR = gdn_pkg::MAX_YEAR_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          mode,
	input  logic [13:0]         year,
	input  logic [3:0]          month,
	input  logic [4:0]          day,
	input  logic [21:0]         day_number,
	input  logic signed [22:0]  offset,
	output logic                out_valid,
	input  logic                out_stall,
	output gdn_pkg::srch_t      out_item
);
	import gdn_pkg::*;

	localparam longint EndDays = longint'(MAX_YEAR) * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
		+ MAX_YEAR / 400;
	localparam logic [21:0] MaxCount = (EndDays > COUNT_LIMIT) ? 22'(COUNT_LIMIT) : 22'(EndDays);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	// stage 1 registers
	mode_t              mode_s1;
	logic [13:0]        year_s1;
	logic [3:0]         month_s1;
	logic [4:0]         day_s1;
	logic [21:0]        dn_s1;
	logic signed [22:0] off_s1;
	logic [9:0]         q_s1;

	// stage 2 registers
	mode_t              mode_s2;
	logic [3:0]         month_s2;
	logic [4:0]         day_s2;
	logic [21:0]        dn_s2;
	logic signed [22:0] off_s2;
	logic [22:0]        dbe_s2;
	logic               leap_s2;
	logic               dval_s2;

	// stage 3 registers
	mode_t              mode_s3;
	logic [21:0]        dn_s3;
	logic signed [22:0] off_s3;
	logic [23:0]        base_s3;
	logic               dval_s3;

	logic [13:0]        ym1;
	logic [13:0]        ym1_s1;
	logic [13:0]        r100;
	logic               cent;
	logic               leap;
	logic [8:0]         mlen;
	logic               dval;
	logic [25:0]        dbe_n;
	logic [23:0]        base_n;
	logic               base_ok;
	logic signed [25:0] sum;
	logic               sum_ok;
	srch_t              item_n;

	// stall chain, a stage loads when empty or when it drains
	assign en_s4     = !vld_s4 || !out_stall;
	assign en_s3     = !vld_s3 || en_s4;
	assign en_s2     = !vld_s2 || en_s3;
	assign en_s1     = !vld_s1 || en_s2;
	assign in_stall  = !en_s1;
	assign out_valid = vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
		end
	end

	// stage 1: capture request, divide year minus one by a hundred
	assign ym1 = year - 14'd1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mode_s1  <= mode_t'(mode);
			year_s1  <= year;
			month_s1 <= month;
			day_s1   <= day;
			dn_s1    <= day_number;
			off_s1   <= offset;
			q_s1     <= div100({2'b00, ym1});
		end
	end

	// stage 2: leap year, date check, days in whole years before
	assign ym1_s1 = year_s1 - 14'd1;
	assign r100   = ym1_s1 - 14'({4'd0, q_s1} * 14'd100);
	assign cent   = (r100 == 14'd99);
	assign leap   = ((year_s1[1:0] == 2'b00) && !cent) || (cent && (q_s1[1:0] == 2'b11));
	assign mlen   = month_start(leap, month_s1) - month_start(leap, month_s1 - 4'd1);
	assign dval   = (year_s1 != 14'd0) && (17'(year_s1) <= 17'(MAX_YEAR))
		&& (month_s1 >= 4'd1) && (month_s1 <= 4'd12)
		&& (day_s1 != 5'd0) && (9'(day_s1) <= mlen);
	assign dbe_n  = dbe({2'b00, ym1_s1}, q_s1);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			mode_s2  <= mode_s1;
			month_s2 <= month_s1;
			day_s2   <= day_s1;
			dn_s2    <= dn_s1;
			off_s2   <= off_s1;
			dbe_s2   <= dbe_n[22:0];
			leap_s2  <= leap;
			dval_s2  <= dval;
		end
	end

	// stage 3: day number of the date
	assign base_n = 24'(dbe_s2) + 24'(month_start(leap_s2, month_s2 - 4'd1)) + 24'(day_s2);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			mode_s3 <= mode_s2;
			dn_s3   <= dn_s2;
			off_s3  <= off_s2;
			base_s3 <= base_n;
			dval_s3 <= dval_s2;
		end
	end

	// stage 4: add offset and pick the day number by mode
	assign base_ok = dval_s3 && (base_s3 <= 24'(MaxCount));
	assign sum     = $signed({2'b00, base_s3}) + $signed({{3{off_s3[22]}}, off_s3});
	assign sum_ok  = !sum[25] && (sum != 26'sd0) && (sum[24:0] <= 25'(MaxCount));

	always_comb begin
		item_n.yr  = '0;
		item_n.dbe = '0;
		unique case (mode_s3)
			MODE_TO_COUNT: begin
				item_n.cnt = base_s3[21:0];
				item_n.ok  = base_ok;
			end
			MODE_TO_DATE: begin
				item_n.cnt = dn_s3;
				item_n.ok  = (dn_s3 != 22'd0) && (dn_s3 <= MaxCount);
			end
			MODE_ADD: begin
				item_n.cnt = sum[21:0];
				item_n.ok  = base_ok && sum_ok;
			end
			default: begin
				item_n.cnt = '0;
				item_n.ok  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			out_item <= item_n;
		end
	end

endmodule

FILE: rtl/core/gdn_year_step.sv
// one bit of the year search: keep the bit when the years before stay below the count
module gdn_year_step #(
	parameter int BIT = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  gdn_pkg::srch_t in_item,
	output logic           out_valid,
	input  logic           out_stall,
	output gdn_pkg::srch_t out_item
);
	import gdn_pkg::*;

	localparam logic [YEAR_BITS-1:0] Mask = YEAR_BITS'(1) << BIT;

	logic                 vld_s1;
	logic                 en_s1;
	logic [YEAR_BITS-1:0] t;
	logic [25:0]          d;
	logic                 take;
	srch_t                item_n;

	assign en_s1     = !vld_s1 || !out_stall;
	assign in_stall  = !en_s1;
	assign out_valid = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= in_valid;
		end
	end

	// trial year and the days it covers
	assign t    = in_item.yr | Mask;
	assign d    = dbe(t, div100(t));
	assign take = d < 26'(in_item.cnt);

	always_comb begin
		item_n     = in_item;
		if (take) begin
			item_n.yr  = t;
			item_n.dbe = d[21:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			out_item <= item_n;
		end
	end

endmodule

FILE: rtl/core/gdn_back.sv
// back stages: day of year, leap year, month and day, weekday
module gdn_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  gdn_pkg::srch_t in_item,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [21:0]    count_out,
	output logic [13:0]    year_out,
	output logic [3:0]     month_out,
	output logic [4:0]     day_out,
	output logic [2:0]     weekday,
	output logic           range_error
);
	import gdn_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	logic [YEAR_BITS-1:0] yr_s1;
	logic [9:0]           q_s1;
	logic [8:0]           rem_s1;
	logic [2:0]           wd_s1;
	logic [21:0]          cnt_s1;
	logic                 ok_s1;

	logic [13:0]          y_s2;
	logic                 leap_s2;
	logic [8:0]           rem_s2;
	logic [2:0]           wd_s2;
	logic [21:0]          cnt_s2;
	logic                 ok_s2;

	logic [13:0]          y_s3;
	logic                 leap_s3;
	logic [8:0]           rem_s3;
	logic [3:0]           mo_s3;
	logic [2:0]           wd_s3;
	logic [21:0]          cnt_s3;
	logic                 ok_s3;

	logic [21:0]          rem_n;
	logic [YEAR_BITS-1:0] r100;
	logic [YEAR_BITS-1:0] y1;
	logic                 cent;
	logic                 leap;
	logic [3:0]           mo_n;
	logic [8:0]           day_n;

	// stall chain
	assign en_s4     = !vld_s4 || !out_stall;
	assign en_s3     = !vld_s3 || en_s4;
	assign en_s2     = !vld_s2 || en_s3;
	assign en_s1     = !vld_s1 || en_s2;
	assign in_stall  = !en_s1;
	assign out_valid = vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
		end
	end

	// stage 1: day within the year, weekday, completed years over a hundred
	assign rem_n = in_item.cnt - in_item.dbe;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			yr_s1  <= in_item.yr;
			q_s1   <= div100(in_item.yr);
			rem_s1 <= rem_n[8:0];
			wd_s1  <= mod7(in_item.cnt);
			cnt_s1 <= in_item.cnt;
			ok_s1  <= in_item.ok;
		end
	end

	// stage 2: leap flag of the found year
	assign r100 = yr_s1 - YEAR_BITS'({6'd0, q_s1} * 16'd100);
	assign cent = (r100 == YEAR_BITS'(99));
	assign y1   = yr_s1 + YEAR_BITS'(1);
	assign leap = ((y1[1:0] == 2'b00) && !cent) || (cent && (q_s1[1:0] == 2'b11));

	always_ff @(posedge clk) begin
		if (en_s2) begin
			y_s2    <= y1[13:0];
			leap_s2 <= leap;
			rem_s2  <= rem_s1;
			wd_s2   <= wd_s1;
			cnt_s2  <= cnt_s1;
			ok_s2   <= ok_s1;
		end
	end

	// stage 3: month from the cumulative month table
	always_comb begin
		mo_n = 4'd1;
		for (int k = 1; k <= 11; k++) begin
			if (month_start(leap_s2, 4'(k)) < rem_s2) mo_n = mo_n + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			y_s3    <= y_s2;
			leap_s3 <= leap_s2;
			rem_s3  <= rem_s2;
			mo_s3   <= mo_n;
			wd_s3   <= wd_s2;
			cnt_s3  <= cnt_s2;
			ok_s3   <= ok_s2;
		end
	end

	// stage 4: day of month, results cleared on error
	assign day_n = rem_s3 - month_start(leap_s3, mo_s3 - 4'd1);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			count_out   <= ok_s3 ? cnt_s3 : 22'd0;
			year_out    <= ok_s3 ? y_s3 : 14'd0;
			month_out   <= ok_s3 ? mo_s3 : 4'd0;
			day_out     <= ok_s3 ? day_n[4:0] : 5'd0;
			weekday     <= ok_s3 ? wd_s3 : 3'd0;
			range_error <= !ok_s3;
		end
	end

endmodule

FILE: rtl/core/gregorian_day_number_converter.sv
// The pipeline has 4 front stages, 16 search stages and 4 back stages.
// Throughput: one request per cycle while no stall holds the pipeline; the 16-stage year
// search, one year bit per stage, sets the depth and every stage is fully pipelined.
// A stall holds each full stage; empty stages keep filling, so nothing is lost or repeated.
// Reset: arst_n clears every stage valid bit at once; data registers are not reset.
// top level of the proleptic Gregorian day number converter
module gregorian_day_number_converter #(
	parameter int MAX_YEAR = gdn_pkg::MAX_YEAR_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         mode,
	input  logic [13:0]        year,
	input  logic [3:0]         month,
	input  logic [4:0]         day,
	input  logic [21:0]        day_number,
	input  logic signed [22:0] offset,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [21:0]        count_out,
	output logic [13:0]        year_out,
	output logic [3:0]         month_out,
	output logic [4:0]         day_out,
	output logic [2:0]         weekday,
	output logic               range_error
);
	import gdn_pkg::*;

	srch_t link_item  [0:YEAR_BITS];
	logic  link_valid [0:YEAR_BITS];
	logic  link_stall [0:YEAR_BITS];

	// date checks and day number
	gdn_front #(
		.MAX_YEAR (MAX_YEAR)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req_valid),
		.in_stall   (req_stall),
		.mode       (mode),
		.year       (year),
		.month      (month),
		.day        (day),
		.day_number (day_number),
		.offset     (offset),
		.out_valid  (link_valid[0]),
		.out_stall  (link_stall[0]),
		.out_item   (link_item[0])
	);

	// year search, most significant bit first
	for (genvar g = 0; g < YEAR_BITS; g++) begin : g_search
		gdn_year_step #(
			.BIT (YEAR_BITS - 1 - g)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_valid[g]),
			.in_stall  (link_stall[g]),
			.in_item   (link_item[g]),
			.out_valid (link_valid[g+1]),
			.out_stall (link_stall[g+1]),
			.out_item  (link_item[g+1])
		);
	end

	// month, day and weekday
	gdn_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (link_valid[YEAR_BITS]),
		.in_stall    (link_stall[YEAR_BITS]),
		.in_item     (link_item[YEAR_BITS]),
		.out_valid   (res_valid),
		.out_stall   (res_stall),
		.count_out   (count_out),
		.year_out    (year_out),
		.month_out   (month_out),
		.day_out     (day_out),
		.weekday     (weekday),
		.range_error (range_error)
	);

endmodule

FILE: rtl/core/gdn_checker.sv
// port checks for the day number converter, bound to the top level
module gdn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_stall,
	input logic [21:0] count_out,
	input logic [13:0] year_out,
	input logic [3:0]  month_out,
	input logic [4:0]  day_out,
	input logic [2:0]  weekday,
	input logic        range_error
);

	// a refused request gives all-zero fields
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && range_error |-> count_out == 22'd0 && year_out == 14'd0
			&& month_out == 4'd0 && day_out == 5'd0 && weekday == 3'd0)
		else $error("error result with non-zero fields");

	// a good result is a real date
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !range_error |-> count_out != 22'd0 && year_out != 14'd0
			&& month_out >= 4'd1 && month_out <= 4'd12 && day_out != 5'd0 && weekday <= 3'd6)
		else $error("good result out of calendar range");

	// february never runs past the twenty-ninth
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !range_error && month_out == 4'd2 |-> day_out <= 5'd29)
		else $error("february day out of range");

	// day one falls on a monday
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !range_error && count_out == 22'd1 |-> weekday == 3'd1
			&& year_out == 14'd1 && month_out == 4'd1 && day_out == 5'd1)
		else $error("first day mis-mapped");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(count_out) && $stable(range_error))
		else $error("stalled result changed");

endmodule

bind gregorian_day_number_converter gdn_checker u_gdn_checker (.*);

FILE: tb/tb.sv
// self-checking testbench for the gregorian day number converter
`timescale 1ns / 1ps

module tb;
	import gdn_pkg::*;

	// calendar limits the predictor works to
	localparam longint YEAR_LAST = MAX_YEAR_DEF;
	localparam longint DAYS_TO_LAST = YEAR_LAST * 365 + YEAR_LAST / 4 - YEAR_LAST / 100
		+ YEAR_LAST / 400;
	localparam longint LAST_DAY = (DAYS_TO_LAST > COUNT_LIMIT) ? COUNT_LIMIT : DAYS_TO_LAST;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 30;

	typedef struct packed {
		logic [21:0] count;
		logic [13:0] yr;
		logic [3:0]  mon;
		logic [4:0]  dom;
		logic [2:0]  wday;
		logic        err;
	} date_result_t;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic [1:0]         mode;
	logic [13:0]        year;
	logic [3:0]         month;
	logic [4:0]         day;
	logic [21:0]        day_number;
	logic signed [22:0] offset;
	logic               res_valid;
	logic               res_stall;
	logic [21:0]        count_out;
	logic [13:0]        year_out;
	logic [3:0]         month_out;
	logic [4:0]         day_out;
	logic [2:0]         weekday;
	logic               range_error;

	date_result_t pending_dates[$];
	int           fail_count = 0;
	int           cycle_count = 0;
	int           burst_left = 0;

	gregorian_day_number_converter u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.mode        (mode),
		.year        (year),
		.month       (month),
		.day         (day),
		.day_number  (day_number),
		.offset      (offset),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.count_out   (count_out),
		.year_out    (year_out),
		.month_out   (month_out),
		.day_out     (day_out),
		.weekday     (weekday),
		.range_error (range_error)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// days in years one to y
	function automatic longint days_through_year(longint y);
		return y * 365 + y / 4 - y / 100 + y / 400;
	endfunction

	function automatic bit leap_year(longint y);
		return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
	endfunction

	function automatic int month_days(longint y, int m);
		case (m)
			2:           return leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	// day number of a date, zero when the date is not a real one within range
	function automatic longint day_of_date(longint y, int m, int d);
		longint n;
		if (y < 1 || y > YEAR_LAST || m < 1 || m > 12 || d < 1 || d > month_days(y, m))
			return 0;
		n = days_through_year(y - 1) + d;
		for (int k = 1; k < m; k++)
			n += month_days(y, k);
		return n;
	endfunction

	// expected conversion of one request
	function automatic date_result_t convert_date(mode_t md, logic [13:0] y, logic [3:0] m,
			logic [4:0] d, logic [21:0] dn, logic signed [22:0] off);
		date_result_t r;
		longint n;
		longint yr;
		longint rem;
		int mon;
		r = '0;
		r.err = 1'b1;
		case (md)
			MODE_TO_COUNT: n = day_of_date(y, m, d);
			MODE_TO_DATE:  n = dn;
			MODE_ADD: begin
				n = day_of_date(y, m, d);
				if (n != 0)
					n = n + longint'(off);
			end
			default: n = 0;
		endcase
		if (n < 1 || n > LAST_DAY)
			return r;
		// first year whose end reaches the count, then walk the months
		yr = n / 366;
		while (days_through_year(yr) < n)
			yr++;
		rem = n - days_through_year(yr - 1);
		mon = 1;
		while (rem > month_days(yr, mon)) begin
			rem -= month_days(yr, mon);
			mon++;
		end
		r.count = 22'(n);
		r.yr    = 14'(yr);
		r.mon   = 4'(mon);
		r.dom   = 5'(rem);
		r.wday  = 3'(n % 7);
		r.err   = 1'b0;
		return r;
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want)
			note_failure($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
	endtask

	// idle cycles before the next request: mostly none or short, a few long
	function automatic int next_gap();
		int pick;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (pick < 55)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// drive one request and wait until it is taken
	task automatic send_request(mode_t md, logic [13:0] y, logic [3:0] m, logic [4:0] d,
			logic [21:0] dn, logic signed [22:0] off);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			@(negedge clk) req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid  <= 1'b1;
		mode       <= md;
		year       <= y;
		month      <= m;
		day        <= d;
		day_number <= dn;
		offset     <= off;
		do
			@(posedge clk);
		while (req_stall);
		pending_dates.push_back(convert_date(md, y, m, d, dn, off));
	endtask

	// a date, weighted towards leap days and the ends of the calendar; may be February 29 of a non-leap century year
	task automatic pick_date(output logic [13:0] y, output logic [3:0] m, output logic [4:0] d);
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			y = 14'($urandom_range(1, 99) * 100);
			m = 4'd2;
		end else if (sel == 1) begin
			y = 14'($urandom_range(1, 2499) * 4);
			m = 4'd2;
		end else if (sel == 2) begin
			y = $urandom_range(0, 1) ? 14'd1 : 14'(YEAR_LAST);
			m = $urandom_range(0, 1) ? 4'd1 : 4'd12;
		end else begin
			y = 14'($urandom_range(1, YEAR_LAST));
			m = 4'($urandom_range(1, 12));
		end
		if (sel < 2)
			d = 5'($urandom_range(28, 29));
		else if ($urandom_range(0, 3) == 0)
			d = $urandom_range(0, 1) ? 5'd1 : 5'(month_days(y, m));
		else
			d = 5'($urandom_range(1, month_days(y, m)));
	endtask

	// break the year, month or day of a date; the day case picks a new month and may still leave a real date
	task automatic spoil_date(inout logic [13:0] y, inout logic [3:0] m, inout logic [4:0] d);
		case ($urandom_range(0, 3))
			0: y = $urandom_range(0, 1) ? 14'd0 : 14'($urandom_range(YEAR_LAST + 1, 16383));
			1: m = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
			2: d = 5'd0;
			default: begin
				m = 4'($urandom_range(1, 12));
				d = 5'($urandom_range(month_days(y, m) + 1, 31));
			end
		endcase
	endtask

	// extremes, leap rules and every error case
	task automatic test_directed();
		send_request(MODE_TO_COUNT, 14'd1, 4'd1, 5'd1, 22'h3FFFFF, 23'h7FFFFF);
		send_request(MODE_TO_COUNT, 14'd9999, 4'd12, 5'd31, 22'd0, 23'd0);
		send_request(MODE_TO_COUNT, 14'd2000, 4'd2, 5'd29, 22'd0, 23'd0);
		send_request(MODE_TO_COUNT, 14'd1900, 4'd2, 5'd29, 22'd0, 23'd0);
		send_request(MODE_TO_COUNT, 14'd2023, 4'd2, 5'd29, 22'd0, 23'd0);
		send_request(MODE_TO_COUNT, 14'd0, 4'd6, 5'd15, 22'd0, 23'd0);
		send_request(MODE_TO_COUNT, 14'd10000, 4'd1, 5'd1, 22'd0, 23'd0);
		send_request(MODE_TO_COUNT, 14'h3FFF, 4'hF, 5'h1F, 22'h3FFFFF, 23'h7FFFFF);
		send_request(MODE_TO_COUNT, 14'd2024, 4'd0, 5'd1, 22'd0, 23'd0);
		send_request(MODE_TO_COUNT, 14'd2024, 4'd13, 5'd1, 22'd0, 23'd0);
		send_request(MODE_TO_COUNT, 14'd2024, 4'd4, 5'd31, 22'd0, 23'd0);
		send_request(MODE_TO_COUNT, 14'd2024, 4'd7, 5'd0, 22'd0, 23'd0);
		send_request(MODE_TO_DATE, 14'd0, 4'd0, 5'd0, 22'd0, 23'd0);
		send_request(MODE_TO_DATE, 14'd0, 4'd0, 5'd0, 22'd1, 23'd0);
		send_request(MODE_TO_DATE, 14'd0, 4'd0, 5'd0, 22'(LAST_DAY), 23'd0);
		send_request(MODE_TO_DATE, 14'd0, 4'd0, 5'd0, 22'(LAST_DAY + 1), 23'd0);
		send_request(MODE_TO_DATE, 14'h3FFF, 4'hF, 5'h1F, 22'h3FFFFF, 23'h7FFFFF);
		send_request(MODE_ADD, 14'd1, 4'd1, 5'd1, 22'd0, -23'sd1);
		send_request(MODE_ADD, 14'd1, 4'd1, 5'd1, 22'd0, 23'sd0);
		send_request(MODE_ADD, 14'd9999, 4'd12, 5'd31, 22'd0, 23'sd1);
		send_request(MODE_ADD, 14'd9999, 4'd12, 5'd31, 22'd0, 23'(-(LAST_DAY - 1)));
		send_request(MODE_ADD, 14'd1, 4'd1, 5'd1, 22'd0, 23'h3FFFFF);
		send_request(MODE_ADD, 14'd5000, 4'd6, 5'd15, 22'd0, 23'h400000);
		send_request(MODE_ADD, 14'd2023, 4'd2, 5'd29, 22'd0, 23'sd0);
		send_request(MODE_NONE, 14'd2000, 4'd1, 5'd1, 22'd100, 23'sd0);
	endtask

	// dates to day numbers, with a share of impossible dates
	task automatic test_date_to_count(int n_req);
		logic [13:0] y;
		logic [3:0]  m;
		logic [4:0]  d;
		for (int i = 0; i < n_req; i++) begin
			pick_date(y, m, d);
			if ($urandom_range(0, 99) < 15)
				spoil_date(y, m, d);
			send_request(MODE_TO_COUNT, y, m, d, 22'($urandom), 23'($urandom));
		end
	endtask

	// day numbers to dates, crowded around year ends and the range limits
	task automatic test_count_to_date(int n_req);
		longint c;
		int sel;
		for (int i = 0; i < n_req; i++) begin
			sel = $urandom_range(0, 9);
			if (sel < 4)
				c = $urandom_range(1, LAST_DAY);
			else if (sel < 7)
				c = days_through_year($urandom_range(0, YEAR_LAST)) + $urandom_range(0, 2) - 1;
			else if (sel == 7)
				c = $urandom_range(0, 1) ? $urandom_range(0, 2) : LAST_DAY + $urandom_range(0, 2) - 1;
			else
				c = $urandom_range(0, 22'h3FFFFF);
			if (c < 0)
				c = 0;
			send_request(MODE_TO_DATE, 14'($urandom), 4'($urandom), 5'($urandom), 22'(c),
				23'($urandom));
		end
	endtask

	// date plus a signed offset, half of them short hops, with some to the range limits
	task automatic test_date_offset(int n_req);
		logic [13:0] y;
		logic [3:0]  m;
		logic [4:0]  d;
		longint base;
		longint o;
		int sel;
		for (int i = 0; i < n_req; i++) begin
			pick_date(y, m, d);
			base = day_of_date(y, m, d);
			sel = $urandom_range(0, 19);
			if (sel < 10)
				o = longint'($urandom_range(0, 800)) - 400;
			else if (sel < 14)
				o = $urandom_range(0, 1) ? -longint'($urandom_range(0, LAST_DAY))
					: longint'($urandom_range(0, LAST_DAY));
			else if (sel < 17)
				o = ($urandom_range(0, 1) ? longint'($urandom_range(0, 2))
					: LAST_DAY + $urandom_range(0, 2) - 1) - base;
			else
				o = $signed(23'($urandom));
			if (sel == 19)
				spoil_date(y, m, d);
			send_request(MODE_ADD, y, m, d, 22'($urandom), 23'(o));
		end
	endtask

	// any mode with loosely shaped fields
	task automatic test_mixed(int n_req);
		mode_t md;
		logic [13:0] y;
		logic [3:0]  m;
		logic [4:0]  d;
		logic signed [22:0] off;
		for (int i = 0; i < n_req; i++) begin
			md = mode_t'($urandom_range(0, 3));
			if ($urandom_range(0, 1)) begin
				pick_date(y, m, d);
				off = 23'(longint'($urandom_range(0, 60000)) - 30000);
			end else begin
				y = 14'($urandom);
				m = 4'($urandom);
				d = 5'($urandom);
				off = 23'($urandom);
			end
			send_request(md, y, m, d,
				$urandom_range(0, 1) ? 22'($urandom_range(1, LAST_DAY)) : 22'($urandom), off);
		end
	endtask

	// result side stall: short holds between short runs, occasional long ones
	initial begin
		int free_len;
		int hold_len;
		res_stall = 1'b0;
		forever begin
			free_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 8);
			@(negedge clk) res_stall <= 1'b0;
			repeat (free_len - 1) @(negedge clk);
			hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
				: $urandom_range(1, 3);
			@(negedge clk) res_stall <= 1'b1;
			repeat (hold_len - 1) @(negedge clk);
		end
	end

	// compare each result with the oldest outstanding request
	always @(posedge clk) begin
		date_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_dates.size() == 0) begin
				note_failure("result with no request outstanding");
			end else begin
				want = pending_dates.pop_front();
				check_field("count_out", 32'(want.count), 32'(count_out));
				check_field("year_out", 32'(want.yr), 32'(year_out));
				check_field("month_out", 32'(want.mon), 32'(month_out));
				check_field("day_out", 32'(want.dom), 32'(day_out));
				check_field("weekday", 32'(want.wday), 32'(weekday));
				check_field("range_error", 32'(want.err), 32'(range_error));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("gregorian_day_number_converter regression: fail");
			$finish;
		end
	end

	// test sequence
	initial begin
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		mode       = MODE_TO_COUNT;
		year       = '0;
		month      = '0;
		day        = '0;
		day_number = '0;
		offset     = '0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_directed();
		test_date_to_count(300);
		test_count_to_date(300);
		test_date_offset(400);
		test_mixed(300);

		// drain
		@(negedge clk) req_valid <= 1'b0;
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_dates.size() == 0)
			$display("gregorian_day_number_converter regression: pass");
		else
			$display("gregorian_day_number_converter regression: fail");
		$finish;
	end

endmodule
